@@ hdl/rend_pkg.sv @@
// Package for the random early NACK decider: field widths, register indexes,
// verdict codes, reset values and the controller/datapath command structs.
// No dependencies.
`default_nettype none
package rend_pkg;

  localparam int QW = 24;            // queue length and threshold width, Q16.8
  localparam int PW = 16;            // probability and random fraction width
  localparam int CW = 16;            // since-reject count width
  localparam int AW = 16;            // multiplier narrow operand width
  localparam int BW = QW + PW;       // multiplier wide operand width
  localparam int MW = AW + BW;       // product width
  localparam int IXW = 2;            // configuration index width

  localparam logic       RST_ENABLE   = 1'b1;
  localparam logic [QW-1:0] RST_MIN_TH = 24'd1280;   // 5.0 packets
  localparam logic [QW-1:0] RST_MAX_TH = 24'd3840;   // 15.0 packets
  localparam logic [PW-1:0] RST_MAX_PROB = 16'd1311; // about 0.02

  typedef enum logic [IXW-1:0] {
    REG_ENABLE   = 2'd0,
    REG_MIN_TH   = 2'd1,
    REG_MAX_TH   = 2'd2,
    REG_MAX_PROB = 2'd3
  } rend_reg_t;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_MAX  = 2'd1,
    VERDICT_PROB = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    MUL_SEL_N  = 2'd0,
    MUL_SEL_CN = 2'd1,
    MUL_SEL_R  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     emit;
  } rend_cmd_t;

  typedef struct packed {
    logic prob_path;
  } rend_sts_t;

endpackage
`default_nettype wire

@@ hdl/rend_if.sv @@
// Valid/ready channel interfaces for request items and decision items.
// Depends on rend_pkg for the field widths.
`default_nettype none
interface rend_in_if import rend_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [QW-1:0] avg_queue_len;
  logic [15:0]   inst_queue_len;
  logic [PW-1:0] rand_value;

  modport source(output valid, output avg_queue_len, output inst_queue_len,
                 output rand_value, input ready);
  modport sink(input valid, input avg_queue_len, input inst_queue_len,
               input rand_value, output ready);
endinterface

interface rend_out_if ();
  logic       valid;
  logic       ready;
  logic       reject;
  logic [1:0] verdict;

  modport source(output valid, output reject, output verdict, input ready);
  modport sink(input valid, input reject, input verdict, output ready);
endinterface
`default_nettype wire

@@ hdl/rend_ctrl.sv @@
// Controller of the random early NACK decider: sequences the load, the three
// shared multiplications and the result emission. Depends on rend_pkg.
`default_nettype none
module rend_ctrl import rend_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rend_sts_t sts,
  output rend_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL_N  = 5'b00010,
    S_MUL_CN = 5'b00100,
    S_MUL_R  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = MUL_SEL_N;
    cmd.emit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.prob_path ? S_MUL_N : S_EMIT;
        end
      end
      S_MUL_N: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_N;
        state_nxt   = S_MUL_CN;
      end
      S_MUL_CN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_CN;
        state_nxt   = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_R;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rend_dp.sv @@
// Datapath of the random early NACK decider: configuration registers, the
// count and flag state, one shared 16x40 multiplier and the output register.
// Depends on rend_pkg.
`default_nettype none
module rend_dp import rend_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [IXW-1:0]  cfg_index,
  input  wire logic [QW-1:0]   cfg_wdata,
  input  wire logic [QW-1:0]   avg_queue_len,
  input  wire logic [15:0]     inst_queue_len,
  input  wire logic [PW-1:0]   rand_value,
  input  wire rend_cmd_t       cmd,
  output rend_sts_t            sts,
  output logic                 out_reject,
  output logic [1:0]           out_verdict
);

  logic          enable_r;
  logic [QW-1:0] min_th_r, max_th_r;
  logic [PW-1:0] max_prob_r;
  logic [CW-1:0] count_r;
  logic          flag_r;

  logic [QW-1:0] avg_r;
  logic [PW-1:0] rnd_r;
  logic          prob_r;
  verdict_t      verdict_r;
  logic [BW-1:0] n_r;
  logic [MW-1:0] prod_r;
  logic          sat_r;
  logic          reject_r;
  logic [1:0]    out_verdict_r;

  logic          ge_min, ge_max, inst_ok;
  logic [CW-1:0] count_inc;
  logic [BW-1:0] full;
  logic          cn_ge_full;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [MW-1:0] mul_p;
  logic          prob_rej;
  verdict_t      final_verdict;

  assign ge_min  = (avg_queue_len >= min_th_r);
  assign ge_max  = (avg_queue_len >= max_th_r);
  assign inst_ok = (inst_queue_len > 16'd1);
  assign sts.prob_path = enable_r && ge_min && inst_ok && !ge_max && flag_r;

  assign count_inc = (count_r == {CW{1'b1}}) ? count_r : count_r + {{(CW-1){1'b0}}, 1'b1};

  // 65536 * (max - min); max > min whenever this is used.
  assign full       = {max_th_r - min_th_r, 16'd0};
  assign cn_ge_full = (prod_r >= {{(MW-BW){1'b0}}, full});

  always_comb begin
    case (cmd.mul_sel)
      MUL_SEL_N: begin
        mul_a = max_prob_r;
        mul_b = {{(BW-QW){1'b0}}, avg_r - min_th_r};
      end
      MUL_SEL_CN: begin
        mul_a = count_r;
        mul_b = n_r;
      end
      MUL_SEL_R: begin
        mul_a = rnd_r;
        mul_b = full - prod_r[BW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{BW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};

  assign prob_rej = sat_r || (prod_r < {n_r, 16'd0});

  always_comb begin
    if (prob_r) begin
      final_verdict = prob_rej ? VERDICT_PROB : VERDICT_PASS;
    end else begin
      final_verdict = verdict_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= RST_ENABLE;
      min_th_r   <= RST_MIN_TH;
      max_th_r   <= RST_MAX_TH;
      max_prob_r <= RST_MAX_PROB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:   enable_r   <= cfg_wdata[0];
        REG_MIN_TH:   min_th_r   <= cfg_wdata;
        REG_MAX_TH:   max_th_r   <= cfg_wdata;
        REG_MAX_PROB: max_prob_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // Count and flag state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else if (cmd.load && enable_r) begin
      if (!(ge_min && inst_ok)) begin
        flag_r <= 1'b0;
      end else if (!ge_max) begin
        if (!flag_r) begin
          count_r <= {{(CW-1){1'b0}}, 1'b1};
          flag_r  <= 1'b1;
        end else begin
          count_r <= count_inc;
        end
      end
    end else if (cmd.emit && prob_r && prob_rej) begin
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r <= 1'b0;
    end else if (cmd.load) begin
      prob_r <= sts.prob_path;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      avg_r <= avg_queue_len;
      rnd_r <= rand_value;
      if (enable_r && ge_min && inst_ok && ge_max) begin
        verdict_r <= VERDICT_MAX;
      end else begin
        verdict_r <= VERDICT_PASS;
      end
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
      if (cmd.mul_sel == MUL_SEL_N) begin
        n_r <= mul_p[BW-1:0];
      end
      if (cmd.mul_sel == MUL_SEL_R) begin
        sat_r <= cn_ge_full;
      end
    end
    if (cmd.emit) begin
      reject_r      <= (final_verdict != VERDICT_PASS);
      out_verdict_r <= final_verdict;
    end
  end

  assign out_reject  = reject_r;
  assign out_verdict = out_verdict_r;

endmodule
`default_nettype wire

@@ hdl/random_early_nack_decider.sv @@
// Top level of the random early NACK decider: joins the controller and the
// datapath to the request, decision and configuration ports.
// Depends on rend_pkg, rend_if, rend_ctrl and rend_dp.
`default_nettype none
// The block takes one request item at a time and returns exactly one decision
// item for it. Items that pass, that sit at or above the maximum threshold, or
// that only arm the counter on the first crossing of the minimum threshold go
// straight to the emit state. Items between the thresholds with the counter
// armed pass the multiply states first, because the count-corrected probability
// test is done as three chained multiplications (max_probability times the
// excess, the count times that product, and the random fraction times the
// remaining margin) on one shared 16 by 40 bit multiplier, one per cycle. A new
// item is accepted as soon as the controller is back in idle, even while the
// previous decision still waits in the output register. Configuration writes
// are taken at any time but must only be issued while the block is idle.
module random_early_nack_decider import rend_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [IXW-1:0] cfg_index,
  input  wire logic [QW-1:0]  cfg_wdata,
  rend_in_if.sink             in_ch,
  rend_out_if.source          out_ch
);

  rend_cmd_t cmd;
  rend_sts_t sts;

  // The controller owns the handshakes and the sequence of steps.
  rend_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the state and the shared multiplier.
  rend_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .avg_queue_len  (in_ch.avg_queue_len),
    .inst_queue_len (in_ch.inst_queue_len),
    .rand_value     (in_ch.rand_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_reject     (out_ch.reject),
    .out_verdict    (out_ch.verdict)
  );

endmodule
`default_nettype wire

@@ hdl/rend_chk.sv @@
// Port-level checker for the random early NACK decider and its bind statement.
// Depends on rend_pkg and the top level random_early_nack_decider.
`default_nettype none
module rend_chk import rend_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       reject,
  input wire logic [1:0] verdict
);

  // The reject flag agrees with the verdict code whenever a decision is shown.
  a_reject_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (reject == (verdict != VERDICT_PASS)))
    else $error("reject flag disagrees with verdict");

  // Only one item is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

  // No decision is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("decision valid after reset");

  // A stalled decision stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(reject)))
    else $error("stalled decision changed");

endmodule

bind random_early_nack_decider rend_chk u_rend_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .reject    (out_ch.reject),
  .verdict   (out_ch.verdict)
);
`default_nettype wire
